### design/fht_pkg.sv
// ---------------------------------------------------------------------------
// fht_pkg
// shared types, codes and constants of the frame hierarchy transform core
// ---------------------------------------------------------------------------
package fht_pkg;

    localparam int DATA_W             = 32;
    localparam int FRAME_IDX_W        = 6;
    localparam int ELEM_W             = 4;
    localparam int OP_W               = 2;
    localparam int STATUS_W           = 2;
    localparam int PARENT_W           = 7;
    localparam int CFG_W              = 7;
    localparam int AXES               = 3;
    localparam int ROT_LANES          = 9;
    localparam int FRAME_LANES        = 12;
    localparam int PROD_W             = 2 * DATA_W;
    localparam int SUM_W              = PROD_W + 2;
    localparam int DEFAULT_MAX_FRAMES = 64;
    localparam int DEFAULT_FRAC_BITS  = 16;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT = 2'd1;
    localparam logic [OP_W-1:0] OP_DIR   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PARENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT        = 2'd3;

    localparam logic [ELEM_W-1:0] ELEM_OFFSET_X = 4'd9;
    localparam logic [ELEM_W-1:0] ELEM_PARENT   = 4'd12;

    localparam logic [PARENT_W-1:0] PARENT_ROOT = '1;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(DATA_MAX);
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(DATA_MIN);

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [FRAME_IDX_W-1:0]   frame_index;
        logic [ELEM_W-1:0]        element_index;
        logic signed [DATA_W-1:0] element_value;
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic [STATUS_W-1:0]      status;
    } result_t;

endpackage

### design/frame_hierarchy_transform_core.sv
// writes, unused codes and rejected items give their result in the cycle after the transfer
// a transform steps S_FETCH, S_MUL, S_SUM per level, then S_DONE until result_free
// each level is a row read of the frame memory, the 9-multiplier bank, then the sum and clamp
// one item at a time; the next item is taken once the result register can take its result
// reset: every frame a root (parent valid bits cleared), frames_in_use 64
// rotation and translation storage is not cleared and holds garbage until written
// ---------------------------------------------------------------------------
// frame_hierarchy_transform_core
// frame table with a parent chain walk that applies rotation and translation
// per level in signed fixed point with clamped sums
// ---------------------------------------------------------------------------
module frame_hierarchy_transform_core #(
    parameter int MAX_FRAMES = fht_pkg::DEFAULT_MAX_FRAMES,
    parameter int FRAC_BITS  = fht_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  fht_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output fht_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fht_pkg::CFG_W-1:0]     cfg_data
);

    localparam int FRAMES = (MAX_FRAMES < 2 ** fht_pkg::FRAME_IDX_W) ?
                            MAX_FRAMES : 2 ** fht_pkg::FRAME_IDX_W;
    localparam int AW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_SUM,
        S_DONE
    } state_t;

    state_t                               state_reg;
    logic [fht_pkg::CFG_W-1:0]            frames_in_use_reg;
    logic [FRAMES-1:0]                    parent_vld_reg;
    logic [AW-1:0]                        frame_reg;
    logic                                 point_reg;
    logic                                 sat_reg;
    logic signed [fht_pkg::DATA_W-1:0]    vec_reg [fht_pkg::AXES];
    logic                                 result_valid_reg;
    fht_pkg::result_t                     result_reg;

    // frame memory: 9 rotation lanes then 3 translation lanes per row
    logic signed [fht_pkg::DATA_W-1:0]    frame_mem [FRAMES][fht_pkg::FRAME_LANES];
    logic [fht_pkg::PARENT_W-1:0]         parent_mem [FRAMES];

    logic signed [fht_pkg::DATA_W-1:0]    row_rd_reg [fht_pkg::FRAME_LANES];
    logic [fht_pkg::PARENT_W-1:0]         parent_rd_reg;
    logic                                 parent_rd_vld_reg;
    logic signed [fht_pkg::PROD_W-1:0]    prod_reg [fht_pkg::ROT_LANES];

    logic                                 item_fire;
    logic                                 result_free;
    logic                                 result_load;
    logic                                 in_range;
    logic                                 is_walk;
    logic                                 parent_ok;
    logic signed [fht_pkg::DATA_W-1:0]    fi_ext;
    logic [AW-1:0]                        wr_addr;
    logic                                 mem_wr_en;
    logic                                 par_wr_en;
    logic [fht_pkg::PARENT_W-1:0]         par_wr_data;
    logic [fht_pkg::STATUS_W-1:0]         imm_status;
    logic [fht_pkg::PARENT_W-1:0]         parent_eff;
    logic                                 walk_root;
    logic signed [fht_pkg::SUM_W-1:0]     sum [fht_pkg::AXES];
    logic signed [fht_pkg::DATA_W-1:0]    clamp [fht_pkg::AXES];
    logic [fht_pkg::AXES-1:0]             clamp_hit;

    // handshake
    assign result_free  = !result_valid_reg || !result_stall;
    assign item_stall   = (state_reg != S_IDLE) || !result_free;
    assign item_fire    = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // item decode
    assign fi_ext    = fht_pkg::DATA_W'(item.frame_index);
    assign in_range  = ({1'b0, item.frame_index} < frames_in_use_reg)
                    && (int'(item.frame_index) < FRAMES);
    assign is_walk   = (item.operation == fht_pkg::OP_POINT)
                    || (item.operation == fht_pkg::OP_DIR);
    assign parent_ok = item.element_value < fi_ext;
    assign wr_addr   = item.frame_index[AW-1:0];

    assign mem_wr_en = item_fire && (item.operation == fht_pkg::OP_WRITE) && in_range
                    && (item.element_index < fht_pkg::ELEM_W'(fht_pkg::FRAME_LANES));
    assign par_wr_en = item_fire && (item.operation == fht_pkg::OP_WRITE) && in_range
                    && (item.element_index == fht_pkg::ELEM_PARENT) && parent_ok;
    assign par_wr_data = item.element_value[fht_pkg::DATA_W-1] ?
                         fht_pkg::PARENT_ROOT : item.element_value[fht_pkg::PARENT_W-1:0];

    // result register loads on an immediate result or at the end of a walk
    assign result_load = ((state_reg == S_IDLE) && item_fire && !(is_walk && in_range))
                      || ((state_reg == S_DONE) && result_free);

    always_comb
    begin
        if (item.operation != fht_pkg::OP_WRITE && !is_walk)
        begin
            imm_status = fht_pkg::ST_OK;
        end
        else if (!in_range)
        begin
            imm_status = fht_pkg::ST_RANGE;
        end
        else if (item.element_index == fht_pkg::ELEM_PARENT && !parent_ok)
        begin
            imm_status = fht_pkg::ST_BAD_PARENT;
        end
        else
        begin
            imm_status = fht_pkg::ST_OK;
        end
    end

    // parent of the frame at hand; an unwritten parent entry is a root
    assign parent_eff = parent_rd_vld_reg ? parent_rd_reg : fht_pkg::PARENT_ROOT;
    assign walk_root  = parent_eff[fht_pkg::PARENT_W-1];

    // per axis: three floored products plus optional translation, then clamp
    always_comb
    begin
        for (int k = 0; k < fht_pkg::AXES; k++)
        begin
            sum[k] = fht_pkg::SUM_W'(prod_reg[k] >>> FRAC_BITS)
                   + fht_pkg::SUM_W'(prod_reg[fht_pkg::AXES + k] >>> FRAC_BITS)
                   + fht_pkg::SUM_W'(prod_reg[2 * fht_pkg::AXES + k] >>> FRAC_BITS)
                   + (point_reg ? fht_pkg::SUM_W'(row_rd_reg[fht_pkg::ROT_LANES + k])
                                : fht_pkg::SUM_W'(0));
            if (sum[k] > fht_pkg::SUM_MAX)
            begin
                clamp[k]     = fht_pkg::DATA_MAX;
                clamp_hit[k] = 1'b1;
            end
            else if (sum[k] < fht_pkg::SUM_MIN)
            begin
                clamp[k]     = fht_pkg::DATA_MIN;
                clamp_hit[k] = 1'b1;
            end
            else
            begin
                clamp[k]     = sum[k][fht_pkg::DATA_W-1:0];
                clamp_hit[k] = 1'b0;
            end
        end
    end

    // frame and parent memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            frame_mem[wr_addr][item.element_index] <= item.element_value;
        end
        if (par_wr_en)
        begin
            parent_mem[wr_addr] <= par_wr_data;
        end
        if (state_reg == S_FETCH)
        begin
            row_rd_reg        <= frame_mem[frame_reg];
            parent_rd_reg     <= parent_mem[frame_reg];
            parent_rd_vld_reg <= parent_vld_reg[frame_reg];
        end
    end

    // multiplier bank, column-major rotation times vector component
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            for (int c = 0; c < fht_pkg::AXES; c++)
            begin
                for (int k = 0; k < fht_pkg::AXES; k++)
                begin
                    prod_reg[fht_pkg::AXES * c + k] <=
                        fht_pkg::PROD_W'(row_rd_reg[fht_pkg::AXES * c + k])
                        * fht_pkg::PROD_W'(vec_reg[c]);
                end
            end
        end
    end

    // configuration and parent valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= fht_pkg::FRAMES_IN_USE_RESET;
            parent_vld_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frames_in_use_reg <= cfg_data;
            end
            if (par_wr_en)
            begin
                parent_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // walk sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_reg        <= '0;
            point_reg        <= 1'b0;
            sat_reg          <= 1'b0;
            vec_reg          <= '{default: '0};
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        if (is_walk && in_range)
                        begin
                            vec_reg[0] <= item.in_x;
                            vec_reg[1] <= item.in_y;
                            vec_reg[2] <= item.in_z;
                            frame_reg  <= wr_addr;
                            point_reg  <= (item.operation == fht_pkg::OP_POINT);
                            sat_reg    <= 1'b0;
                            state_reg  <= S_FETCH;
                        end
                        else
                        begin
                            result_reg <= '{out_x: '0, out_y: '0, out_z: '0,
                                            status: imm_status};
                        end
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    vec_reg <= clamp;
                    sat_reg <= sat_reg || (clamp_hit != '0);
                    if (walk_root)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        frame_reg <= parent_eff[AW-1:0];
                        state_reg <= S_FETCH;
                    end
                end
                S_DONE:
                begin
                    if (result_free)
                    begin
                        result_reg.out_x  <= vec_reg[0];
                        result_reg.out_y  <= vec_reg[1];
                        result_reg.out_z  <= vec_reg[2];
                        result_reg.status <= sat_reg ? fht_pkg::ST_SAT : fht_pkg::ST_OK;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the walk only climbs toward lower frame indices
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && !walk_root) |-> (parent_eff[AW-1:0] < frame_reg))
        else $error("parent chain does not descend");

    // a finished walk always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && result_free) |=> (result_valid && state_reg == S_IDLE))
        else $error("walk result not delivered");

    // out of range items carry a zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == fht_pkg::ST_RANGE) |->
        (result.out_x == '0 && result.out_y == '0 && result.out_z == '0))
        else $error("out of range result has nonzero vector");
`endif

endmodule

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the frame hierarchy transform core: unused codes,
// directed frame writes and parent checks, walks of frame 0, frame count limits,
// then random traffic under several frame counts; every result is checked field
// by field against an in-bench copy of the frame table and its fixed-point walk
// ---------------------------------------------------------------------------
module tb;

    localparam int FRAMES      = fht_pkg::DEFAULT_MAX_FRAMES;
    localparam int FRAC        = fht_pkg::DEFAULT_FRAC_BITS;
    localparam int WALK_CYCLES = 3 * FRAMES + 2;
    localparam int IDLE_LIMIT  = 4000;
    localparam int ROOT        = -1;

    localparam logic [fht_pkg::OP_W-1:0] OP_NONE = 2'd3;
    localparam logic signed [fht_pkg::DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    fht_pkg::item_t            item         = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    fht_pkg::result_t          result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [fht_pkg::CFG_W-1:0] cfg_data     = '0;

    // mirrored frame table
    logic signed [fht_pkg::DATA_W-1:0] rot_q [FRAMES][fht_pkg::ROT_LANES];
    logic signed [fht_pkg::DATA_W-1:0] off_q [FRAMES][fht_pkg::AXES];
    bit                                rot_set [FRAMES][fht_pkg::ROT_LANES];
    bit                                off_set [FRAMES][fht_pkg::AXES];
    int                                parent_of [FRAMES];
    logic [fht_pkg::CFG_W-1:0]         frames_cfg = fht_pkg::FRAMES_IN_USE_RESET;

    fht_pkg::result_t expected_results [$];

    int errors     = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_walks    = 0;
    int n_sat      = 0;
    int n_rejected = 0;
    int deepest    = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    frame_hierarchy_transform_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int frame_limit();
        return (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    endfunction

    // applies one item to the mirrored table and returns the result it gives
    function automatic fht_pkg::result_t frame_table_step(fht_pkg::item_t it);
        fht_pkg::result_t                  r;
        int                                fi;
        int                                el;
        int                                pv;
        int                                f;
        int                                levels;
        bit                                point;
        bit                                clipped;
        longint                            s;
        logic signed [fht_pkg::DATA_W-1:0] v [fht_pkg::AXES];
        logic signed [fht_pkg::DATA_W-1:0] nv [fht_pkg::AXES];
        r = '0;
        fi = int'(it.frame_index);
        el = int'(it.element_index);
        pv = int'(it.element_value);
        if (it.operation == OP_NONE)
            return r;
        if (fi >= frame_limit())
        begin
            r.status = fht_pkg::ST_RANGE;
            return r;
        end
        if (it.operation == fht_pkg::OP_WRITE)
        begin
            if (el < int'(fht_pkg::ELEM_OFFSET_X))
            begin
                rot_q[fi][el] = it.element_value;
                rot_set[fi][el] = 1'b1;
            end
            else if (el < int'(fht_pkg::ELEM_PARENT))
            begin
                off_q[fi][el - int'(fht_pkg::ELEM_OFFSET_X)] = it.element_value;
                off_set[fi][el - int'(fht_pkg::ELEM_OFFSET_X)] = 1'b1;
            end
            else if (el == int'(fht_pkg::ELEM_PARENT))
            begin
                if (pv >= fi)
                    r.status = fht_pkg::ST_BAD_PARENT;
                else
                    parent_of[fi] = (pv < 0) ? ROOT : pv;
            end
            return r;
        end
        point = (it.operation == fht_pkg::OP_POINT);
        clipped = 1'b0;
        levels = 0;
        v[0] = it.in_x;
        v[1] = it.in_y;
        v[2] = it.in_z;
        f = fi;
        while (f != ROOT)
        begin
            for (int k = 0; k < fht_pkg::AXES; k++)
            begin
                s = ((longint'(rot_q[f][k]) * longint'(v[0])) >>> FRAC)
                  + ((longint'(rot_q[f][fht_pkg::AXES + k]) * longint'(v[1])) >>> FRAC)
                  + ((longint'(rot_q[f][2 * fht_pkg::AXES + k]) * longint'(v[2])) >>> FRAC);
                if (point)
                    s += longint'(off_q[f][k]);
                if (s > longint'(fht_pkg::DATA_MAX))
                begin
                    nv[k] = fht_pkg::DATA_MAX;
                    clipped = 1'b1;
                end
                else if (s < longint'(fht_pkg::DATA_MIN))
                begin
                    nv[k] = fht_pkg::DATA_MIN;
                    clipped = 1'b1;
                end
                else
                    nv[k] = s[fht_pkg::DATA_W-1:0];
            end
            v = nv;
            f = parent_of[f];
            levels++;
        end
        n_walks++;
        if (levels > deepest)
            deepest = levels;
        r.out_x = v[0];
        r.out_y = v[1];
        r.out_z = v[2];
        r.status = clipped ? fht_pkg::ST_SAT : fht_pkg::ST_OK;
        return r;
    endfunction

    // first element on the chain from start that a walk would read unwritten
    function automatic bit first_unwritten(input int start, input bit point,
                                           output int gf, output int ge);
        int f;
        f = start;
        gf = 0;
        ge = 0;
        while (f != ROOT)
        begin
            for (int e = 0; e < fht_pkg::ROT_LANES; e++)
                if (!rot_set[f][e])
                begin
                    gf = f;
                    ge = e;
                    return 1'b1;
                end
            if (point)
                for (int e = 0; e < fht_pkg::AXES; e++)
                    if (!off_set[f][e])
                    begin
                        gf = f;
                        ge = int'(fht_pkg::ELEM_OFFSET_X) + e;
                        return 1'b1;
                    end
            f = parent_of[f];
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [fht_pkg::DATA_W-1:0] rand_q();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 2 << FRAC) - (1 << FRAC);
        if (r < 8)
            return $urandom;
        if (r == 8)
            return $urandom_range(0, 1) ? fht_pkg::DATA_MAX : fht_pkg::DATA_MIN;
        return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
    endfunction

    function automatic logic signed [fht_pkg::DATA_W-1:0] pick_parent(int fi);
        int r;
        r = $urandom_range(0, 9);
        if (fi > 0 && r < 3)
            return fi - 1;
        if (fi > 0 && r < 6)
            return $urandom_range(0, fi - 1);
        if (r < 7)
            return ROOT;
        if (r < 8)
            return $urandom | 32'h8000_0000;
        if (r < 9)
            return fi + $urandom_range(0, 3);
        return $urandom;
    endfunction

    // mostly well-formed: a walk over unwritten frames becomes the missing write
    function automatic fht_pkg::item_t random_item();
        fht_pkg::item_t it;
        int             lim;
        int             r;
        int             gf;
        int             ge;
        lim = frame_limit();
        it.frame_index = fht_pkg::FRAME_IDX_W'((lim > 0 && $urandom_range(0, 19) != 0) ?
                         $urandom_range(0, lim - 1) : $urandom_range(0, FRAMES - 1));
        it.element_index = fht_pkg::ELEM_W'($urandom_range(0, 15));
        it.element_value = rand_q();
        it.in_x = rand_q();
        it.in_y = rand_q();
        it.in_z = rand_q();
        r = $urandom_range(0, 99);
        if (r < 6)
            it.operation = OP_NONE;
        else if (r < 40)
        begin
            it.operation = fht_pkg::OP_WRITE;
            r = $urandom_range(0, 19);
            if (r < 13)
                it.element_index =
                    fht_pkg::ELEM_W'($urandom_range(0, int'(fht_pkg::ELEM_PARENT) - 1));
            else if (r < 18)
            begin
                it.element_index = fht_pkg::ELEM_PARENT;
                it.element_value = pick_parent(int'(it.frame_index));
            end
        end
        else
        begin
            it.operation = $urandom_range(0, 1) ? fht_pkg::OP_POINT : fht_pkg::OP_DIR;
            if (int'(it.frame_index) < lim &&
                first_unwritten(int'(it.frame_index), it.operation == fht_pkg::OP_POINT,
                                gf, ge))
            begin
                it.operation = fht_pkg::OP_WRITE;
                it.frame_index = fht_pkg::FRAME_IDX_W'(gf);
                it.element_index = fht_pkg::ELEM_W'(ge);
                it.element_value = rand_q();
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [fht_pkg::DATA_W-1:0] got,
                                   logic [fht_pkg::DATA_W-1:0] want);
        errors++;
        $display("tb: mismatch on %s: got %h, expected %h (result %0d)",
                 what, got, want, n_results);
    endtask

    task automatic send_item(fht_pkg::item_t it);
        int gap;
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        expected_results.insert(expected_results.size(), frame_table_step(it));
        n_items++;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_elem(int f, int el, logic signed [fht_pkg::DATA_W-1:0] val);
        fht_pkg::item_t it;
        it.operation = fht_pkg::OP_WRITE;
        it.frame_index = fht_pkg::FRAME_IDX_W'(f);
        it.element_index = fht_pkg::ELEM_W'(el);
        it.element_value = val;
        it.in_x = $urandom;
        it.in_y = $urandom;
        it.in_z = $urandom;
        send_item(it);
    endtask

    task automatic walk(logic [fht_pkg::OP_W-1:0] op, int f,
                        logic signed [fht_pkg::DATA_W-1:0] x,
                        logic signed [fht_pkg::DATA_W-1:0] y,
                        logic signed [fht_pkg::DATA_W-1:0] z);
        fht_pkg::item_t it;
        it.operation = op;
        it.frame_index = fht_pkg::FRAME_IDX_W'(f);
        it.element_index = fht_pkg::ELEM_W'($urandom_range(0, 15));
        it.element_value = $urandom;
        it.in_x = x;
        it.in_y = y;
        it.in_z = z;
        send_item(it);
    endtask

    // register writes only once every result is back
    task automatic set_frame_count(logic [fht_pkg::CFG_W-1:0] n);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_data <= n;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        frames_cfg = n;
    endtask

    task automatic test_unused_codes();
        fht_pkg::item_t it;
        it.operation = OP_NONE;
        it.frame_index = fht_pkg::FRAME_IDX_W'($urandom);
        it.element_index = fht_pkg::ELEM_W'($urandom);
        it.element_value = $urandom;
        it.in_x = $urandom;
        it.in_y = $urandom;
        it.in_z = $urandom;
        send_item(it);
        write_elem(5, 15, fht_pkg::DATA_MAX);
    endtask

    task automatic test_frame_zero();
        for (int e = 0; e < fht_pkg::ROT_LANES - 1; e++)
            write_elem(0, e, (e % 4 == 0) ? Q_ONE : '0);
        write_elem(0, fht_pkg::ROT_LANES - 1, fht_pkg::DATA_MIN);
        write_elem(0, int'(fht_pkg::ELEM_OFFSET_X), 32'sh0001_8000);
        write_elem(0, int'(fht_pkg::ELEM_OFFSET_X) + 1, fht_pkg::DATA_MAX);
        write_elem(0, int'(fht_pkg::ELEM_OFFSET_X) + 2, -Q_ONE);
        write_elem(0, int'(fht_pkg::ELEM_PARENT), 0);
        write_elem(1, int'(fht_pkg::ELEM_PARENT), 1);
        write_elem(1, int'(fht_pkg::ELEM_PARENT), 0);
        write_elem(2, int'(fht_pkg::ELEM_PARENT), -5);
        write_elem(3, int'(fht_pkg::ELEM_PARENT), fht_pkg::DATA_MAX);
    endtask

    task automatic test_directed_walks();
        walk(fht_pkg::OP_POINT, 0, fht_pkg::DATA_MAX, -Q_ONE, fht_pkg::DATA_MIN);
        walk(fht_pkg::OP_DIR, 0, Q_ONE, fht_pkg::DATA_MIN, '0);
        walk(fht_pkg::OP_POINT, 0, '0, '0, '0);
    endtask

    task automatic test_frame_count_limits();
        set_frame_count(fht_pkg::CFG_W'(1));
        write_elem(1, 0, Q_ONE);
        walk(fht_pkg::OP_DIR, 0, -Q_ONE, Q_ONE, fht_pkg::DATA_MAX);
        set_frame_count(fht_pkg::CFG_W'(0));
        walk(fht_pkg::OP_POINT, 0, Q_ONE, Q_ONE, Q_ONE);
        set_frame_count(fht_pkg::CFG_W'(127));
        write_elem(63, int'(fht_pkg::ELEM_PARENT), 62);
        write_elem(63, int'(fht_pkg::ELEM_PARENT), 63);
    endtask

    task automatic test_random_traffic(logic [fht_pkg::CFG_W-1:0] n, int count,
                                       bit s_idle, bit r_idle);
        set_frame_count(n);
        sender_idles = s_idle;
        receiver_idles = r_idle;
        repeat (count) send_item(random_item());
    endtask

    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n = receiver_idles ? pick_gap() : 0;
            if (n == 0)
                result_stall <= 1'b0;
            else
            begin
                result_stall <= 1'b1;
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        fht_pkg::result_t want;
        if (result_valid && !result_stall)
        begin
            n_results++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result.out_x, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result.out_x !== want.out_x)
                    report_mismatch("out_x", result.out_x, want.out_x);
                if (result.out_y !== want.out_y)
                    report_mismatch("out_y", result.out_y, want.out_y);
                if (result.out_z !== want.out_z)
                    report_mismatch("out_z", result.out_z, want.out_z);
                if (result.status !== want.status)
                    report_mismatch("status", fht_pkg::DATA_W'(result.status),
                                    fht_pkg::DATA_W'(want.status));
                if (want.status == fht_pkg::ST_SAT)
                    n_sat++;
                if (want.status == fht_pkg::ST_RANGE || want.status == fht_pkg::ST_BAD_PARENT)
                    n_rejected++;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        for (int f = 0; f < FRAMES; f++)
            parent_of[f] = ROOT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unused_codes();
        test_frame_zero();
        test_directed_walks();
        test_frame_count_limits();
        test_random_traffic(fht_pkg::CFG_W'(64), 180, 1'b1, 1'b1);
        test_random_traffic(fht_pkg::CFG_W'(127), 80, 1'b0, 1'b0);
        test_random_traffic(fht_pkg::CFG_W'(1), 40, 1'b1, 1'b0);
        test_random_traffic(fht_pkg::CFG_W'($urandom_range(2, 20)), 120, 1'b1, 1'b1);
        test_random_traffic(fht_pkg::CFG_W'(0), 20, 1'b0, 1'b1);
        test_random_traffic(fht_pkg::CFG_W'($urandom_range(21, 64)), 80, 1'b1, 1'b1);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (WALK_CYCLES) @(posedge clk);
        $display("tb: %0d items sent, %0d results checked, %0d walks, %0d saturated",
                 n_items, n_results, n_walks, n_sat);
        $display("tb: %0d rejected; frame counts 0, 1, 64, 127 and mid-range; deepest %0d",
                 n_rejected, deepest);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

### frame_hierarchy_transform_core.f
design/fht_pkg.sv
design/frame_hierarchy_transform_core.sv
verif/tb.sv
